/* rtl/core/psa_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority scheduler package
// Shared constants, types and the candidate ordering used by the scheduler.
// ----------------------------------------------------------------------------
package psa_pkg;

   localparam int READY_DEPTH_DEF = 16;
   localparam int NUM_CPUS_DEF    = 4;

   localparam logic [1:0] MODE_ADD     = 2'd0;
   localparam logic [1:0] MODE_RELEASE = 2'd1;
   localparam logic [1:0] MODE_TICK    = 2'd2;

   localparam logic REG_QUANTUM = 1'b0;
   localparam logic REG_AGING   = 1'b1;

   localparam logic [7:0] QUANTUM_RESET = 8'd4;
   localparam logic [7:0] AGING_RESET   = 8'd1;

   typedef struct packed {
      logic [7:0]  id;
      logic [7:0]  prio;
      logic [15:0] arr;
      logic [15:0] len;
   } psa_task_type;

   // A candidate for the best ready task, as it travels along the chain.
   typedef struct packed {
      logic        found;
      logic [16:0] eff;
      logic [7:0]  id;
      logic [7:0]  prio;
      logic [15:0] arr;
      logic [15:0] len;
   } psa_cand_type;

   // Per-slot control for one cycle.
   typedef struct packed {
      logic         age_en;
      logic [7:0]   step;
      logic         wr;
      logic         clr;
      psa_task_type data;
   } psa_ctl_type;

   // True when a is strictly better than b (both assumed present).
   function automatic logic better(input psa_cand_type a, input psa_cand_type b);
      logic r;
      if (a.eff != b.eff) begin
         r = a.eff > b.eff;
      end else if (a.prio != b.prio) begin
         r = a.prio > b.prio;
      end else if (a.arr != b.arr) begin
         r = a.arr < b.arr;
      end else begin
         r = a.len < b.len;
      end
      return r;
   endfunction

endpackage

/* rtl/core/psa_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ready store cell
// Holds one task slot and passes the better of its own task and the incoming
// candidate to the next cell every cycle.
// ----------------------------------------------------------------------------
module psa_cell #(
   parameter int SW   = 4,
   parameter int SLOT = 0
) (
   input  logic                 clock,
   input  logic                 reset,
   input  psa_pkg::psa_ctl_type ctl,
   input  psa_pkg::psa_cand_type cand_in,
   input  logic [SW-1:0]        slot_in,
   output psa_pkg::psa_cand_type cand_out,
   output logic [SW-1:0]        slot_out,
   output logic                 valid
);

   logic                  valid_ff;
   psa_pkg::psa_task_type task_ff;
   logic [15:0]           age_ff;
   psa_pkg::psa_cand_type own;
   psa_pkg::psa_cand_type cand_ff, cand_in_w;
   logic [SW-1:0]         slot_ff, slot_in_w;
   logic [16:0]           age_sum;

   assign age_sum = {1'b0, age_ff} + {9'b0, ctl.step};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.wr) begin
         valid_ff <= 1'b1;
      end else if (ctl.clr) begin
         valid_ff <= 1'b0;
      end
      if (ctl.wr) begin
         task_ff <= ctl.data;
         age_ff  <= 16'd0;
      end else if (ctl.age_en && valid_ff) begin
         age_ff <= age_sum[16] ? 16'hFFFF : age_sum[15:0];
      end
   end

   always_comb begin
      own.found = valid_ff;
      own.eff   = {9'b0, task_ff.prio} + {1'b0, age_ff};
      own.id    = task_ff.id;
      own.prio  = task_ff.prio;
      own.arr   = task_ff.arr;
      own.len   = task_ff.len;
      // Lower slots come first, so this slot wins only when strictly better.
      if (own.found && (!cand_in.found || psa_pkg::better(own, cand_in))) begin
         cand_in_w = own;
         slot_in_w = SW'(SLOT);
      end else begin
         cand_in_w = cand_in;
         slot_in_w = slot_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff.found <= 1'b0;
      end else begin
         cand_ff.found <= cand_in_w.found;
      end
      cand_ff.eff  <= cand_in_w.eff;
      cand_ff.id   <= cand_in_w.id;
      cand_ff.prio <= cand_in_w.prio;
      cand_ff.arr  <= cand_in_w.arr;
      cand_ff.len  <= cand_in_w.len;
      slot_ff      <= slot_in_w;
   end

   assign cand_out = cand_ff;
   assign slot_out = slot_ff;
   assign valid    = valid_ff;

endmodule

/* rtl/core/priority_scheduler_with_aging.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Priority scheduler with aging
// Ready store kept in a chain of cells, processors in a small register file,
// and a sequencer that visits each processor on every scheduling tick.
// ----------------------------------------------------------------------------
// Channel   Ports                      Handshake
// request   req_*                      start high while busy low takes a beat
// response  rsp_*                      rsp_valid high for one cycle per beat
// config    csr_we, csr_index, csr_wdata   write when csr_we is high
//
// Add, release and undefined items give their response in the next cycle;
// busy stays low. A tick visits each processor in turn with a quantum expiry
// step, a search step while the best candidate ripples down the cell chain,
// and a decide step. The response for each processor appears in order, the
// last one flagged by rsp_last. Reset is synchronous and leaves all processors
// powered and idle with an empty store. The receiver cannot stall.
// ----------------------------------------------------------------------------
module priority_scheduler_with_aging #(
   parameter int READY_DEPTH = psa_pkg::READY_DEPTH_DEF,
   parameter int NUM_CPUS    = psa_pkg::NUM_CPUS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [7:0]  req_task_id,
   input  logic [7:0]  req_task_priority,
   input  logic [15:0] req_arrival_time,
   input  logic [15:0] req_task_duration,
   input  logic [2:0]  req_cpu_select,
   output logic        rsp_valid,
   output logic [2:0]  rsp_cpu_index,
   output logic        rsp_running_valid,
   output logic [7:0]  rsp_running_task,
   output logic        rsp_cpu_powered,
   output logic        rsp_quantum_expired,
   output logic        rsp_aging_preempted,
   output logic        rsp_newly_assigned,
   output logic        rsp_store_full,
   output logic        rsp_last,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int SW = $clog2(READY_DEPTH);
   localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CPU,
      ST_SEARCH,
      ST_DECIDE
   } state_type;

   state_type state_ff, state_in;
   logic [CW-1:0] cpu_ff, cpu_in;
   logic [SW-1:0] cnt_ff, cnt_in;
   // The spare slot holds an expired task when the store is full; its data
   // stays in the processor's task registers.
   logic          xv_ff, xv_in;
   logic          qe_ff, qe_in;
   logic [7:0]    quantum_ff, quantum_in;
   logic [7:0]    step_ff, step_in;

   logic [NUM_CPUS-1:0] on_ff, on_in;
   logic [NUM_CPUS-1:0] busy_ff, busy_in;
   logic [7:0]  rc_ff  [NUM_CPUS];
   logic [7:0]  rc_in  [NUM_CPUS];
   logic [7:0]  id_ff  [NUM_CPUS];
   logic [7:0]  id_in  [NUM_CPUS];
   logic [7:0]  pr_ff  [NUM_CPUS];
   logic [7:0]  pr_in  [NUM_CPUS];
   logic [15:0] arr_ff [NUM_CPUS];
   logic [15:0] arr_in [NUM_CPUS];
   logic [15:0] len_ff [NUM_CPUS];
   logic [15:0] len_in [NUM_CPUS];

   logic       rsp_valid_ff, rsp_valid_in;
   logic [2:0] rsp_idx_ff, rsp_idx_in;
   logic       rsp_rv_ff, rsp_rv_in;
   logic [7:0] rsp_task_ff, rsp_task_in;
   logic       rsp_pw_ff, rsp_pw_in;
   logic       rsp_qe_ff, rsp_qe_in;
   logic       rsp_ap_ff, rsp_ap_in;
   logic       rsp_na_ff, rsp_na_in;
   logic       rsp_sf_ff, rsp_sf_in;
   logic       rsp_last_ff, rsp_last_in;

   psa_pkg::psa_ctl_type  ctl [READY_DEPTH];
   psa_pkg::psa_cand_type cand_chain [READY_DEPTH+1];
   logic [SW-1:0]         slot_chain [READY_DEPTH+1];
   logic [READY_DEPTH-1:0] cell_valid;

   logic          accept;
   logic          free_any, free2_any;
   logic [SW-1:0] free_idx, free2_idx;
   psa_pkg::psa_cand_type best, ext;
   logic [SW-1:0] bslot;
   logic          any, use_ext;
   logic [7:0]    rc_next;
   logic          sel_ok;
   logic [CW-1:0] sel;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);

   assign cand_chain[0] = '0;
   assign slot_chain[0] = '0;

   for (genvar g = 0; g < READY_DEPTH; g++) begin : g_cell
      psa_cell #(.SW(SW), .SLOT(g)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl[g]),
         .cand_in  (cand_chain[g]),
         .slot_in  (slot_chain[g]),
         .cand_out (cand_chain[g+1]),
         .slot_out (slot_chain[g+1]),
         .valid    (cell_valid[g])
      );
   end

   assign best  = cand_chain[READY_DEPTH];
   assign bslot = slot_chain[READY_DEPTH];

   // Lowest free slot, plain and with the best slot counted as free.
   always_comb begin
      free_any  = 1'b0;
      free_idx  = '0;
      free2_any = 1'b0;
      free2_idx = '0;
      for (int i = READY_DEPTH - 1; i >= 0; i--) begin
         if (!cell_valid[i]) begin
            free_any = 1'b1;
            free_idx = SW'(i);
         end
         if (!cell_valid[i] || (SW'(i) == bslot)) begin
            free2_any = 1'b1;
            free2_idx = SW'(i);
         end
      end
   end

   assign sel    = req_cpu_select[CW-1:0];
   assign sel_ok = ({1'b0, req_cpu_select} < 4'(NUM_CPUS));

   always_comb begin
      ext.found = xv_ff;
      ext.eff   = {9'b0, pr_ff[cpu_ff]};
      ext.id    = id_ff[cpu_ff];
      ext.prio  = pr_ff[cpu_ff];
      ext.arr   = arr_ff[cpu_ff];
      ext.len   = len_ff[cpu_ff];
      any       = best.found || xv_ff;
      use_ext   = xv_ff && (!best.found || psa_pkg::better(ext, best));
      rc_next   = (rc_ff[cpu_ff] == 8'hFF) ? rc_ff[cpu_ff] : rc_ff[cpu_ff] + 8'd1;
   end

   always_comb begin
      state_in   = state_ff;
      cpu_in     = cpu_ff;
      cnt_in     = cnt_ff;
      xv_in      = xv_ff;
      qe_in      = qe_ff;
      quantum_in = quantum_ff;
      step_in    = step_ff;
      on_in      = on_ff;
      busy_in    = busy_ff;
      rc_in      = rc_ff;
      id_in      = id_ff;
      pr_in      = pr_ff;
      arr_in     = arr_ff;
      len_in     = len_ff;

      rsp_valid_in = 1'b0;
      rsp_idx_in   = rsp_idx_ff;
      rsp_rv_in    = rsp_rv_ff;
      rsp_task_in  = rsp_task_ff;
      rsp_pw_in    = rsp_pw_ff;
      rsp_qe_in    = rsp_qe_ff;
      rsp_ap_in    = rsp_ap_ff;
      rsp_na_in    = rsp_na_ff;
      rsp_sf_in    = rsp_sf_ff;
      rsp_last_in  = rsp_last_ff;

      for (int i = 0; i < READY_DEPTH; i++) begin
         ctl[i].age_en = 1'b0;
         ctl[i].step   = step_ff;
         ctl[i].wr     = 1'b0;
         ctl[i].clr    = 1'b0;
         ctl[i].data   = '0;
      end

      if (csr_we) begin
         case (csr_index)
            psa_pkg::REG_QUANTUM: quantum_in = csr_wdata;
            psa_pkg::REG_AGING:   step_in    = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = 3'd0;
               rsp_rv_in    = 1'b0;
               rsp_task_in  = 8'd0;
               rsp_pw_in    = 1'b0;
               rsp_qe_in    = 1'b0;
               rsp_ap_in    = 1'b0;
               rsp_na_in    = 1'b0;
               rsp_sf_in    = 1'b0;
               rsp_last_in  = 1'b1;
               case (req_mode)
                  psa_pkg::MODE_ADD: begin
                     if (free_any) begin
                        ctl[free_idx].wr   = 1'b1;
                        ctl[free_idx].data = '{id: req_task_id, prio: req_task_priority,
                                               arr: req_arrival_time,
                                               len: req_task_duration};
                     end
                     rsp_sf_in = !free_any;
                  end
                  psa_pkg::MODE_RELEASE: begin
                     rsp_idx_in = req_cpu_select;
                     if (sel_ok) begin
                        busy_in[sel] = 1'b0;
                        rc_in[sel]   = 8'd0;
                        rsp_pw_in    = on_ff[sel];
                     end
                  end
                  psa_pkg::MODE_TICK: begin
                     rsp_valid_in = 1'b0;
                     for (int i = 0; i < READY_DEPTH; i++) begin
                        ctl[i].age_en = 1'b1;
                     end
                     cpu_in   = '0;
                     state_in = ST_CPU;
                  end
                  default: ;
               endcase
            end
         end
         ST_CPU: begin
            qe_in = 1'b0;
            if (on_ff[cpu_ff] && busy_ff[cpu_ff]) begin
               rc_in[cpu_ff] = rc_next;
               if (rc_next >= quantum_ff) begin
                  if (free_any) begin
                     ctl[free_idx].wr   = 1'b1;
                     ctl[free_idx].data = '{id: id_ff[cpu_ff], prio: pr_ff[cpu_ff],
                                            arr: arr_ff[cpu_ff], len: len_ff[cpu_ff]};
                  end else begin
                     xv_in = 1'b1;
                  end
                  busy_in[cpu_ff] = 1'b0;
                  rc_in[cpu_ff]   = 8'd0;
                  qe_in           = 1'b1;
               end
            end
            cnt_in   = '0;
            state_in = ST_SEARCH;
         end
         ST_SEARCH: begin
            cnt_in = cnt_ff + SW'(1);
            if (cnt_ff == SW'(READY_DEPTH - 1)) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            rsp_ap_in = 1'b0;
            rsp_na_in = 1'b0;
            if (on_ff[cpu_ff] || any) begin
               on_in[cpu_ff] = 1'b1;
               if (!busy_ff[cpu_ff]) begin
                  if (any) begin
                     rsp_na_in        = 1'b1;
                     busy_in[cpu_ff]  = 1'b1;
                     rc_in[cpu_ff]    = 8'd0;
                     xv_in            = 1'b0;
                     if (!use_ext) begin
                        id_in[cpu_ff]  = best.id;
                        pr_in[cpu_ff]  = best.prio;
                        arr_in[cpu_ff] = best.arr;
                        len_in[cpu_ff] = best.len;
                        ctl[bslot].clr = 1'b1;
                        if (xv_ff) begin
                           // The spare task fills the slot just vacated.
                           ctl[bslot].wr   = 1'b1;
                           ctl[bslot].data = '{id: ext.id, prio: ext.prio,
                                               arr: ext.arr, len: ext.len};
                        end
                     end
                  end else begin
                     on_in[cpu_ff] = 1'b0;
                  end
               end else if (best.found && (best.eff > {9'b0, pr_ff[cpu_ff]})) begin
                  // Preemption: swap the running task with the best one.
                  rsp_ap_in      = 1'b1;
                  rsp_na_in      = 1'b1;
                  rc_in[cpu_ff]  = 8'd0;
                  id_in[cpu_ff]  = best.id;
                  pr_in[cpu_ff]  = best.prio;
                  arr_in[cpu_ff] = best.arr;
                  len_in[cpu_ff] = best.len;
                  ctl[bslot].clr = 1'b1;
                  if (free2_any) begin
                     ctl[free2_idx].wr   = 1'b1;
                     ctl[free2_idx].data = '{id: id_ff[cpu_ff], prio: pr_ff[cpu_ff],
                                             arr: arr_ff[cpu_ff], len: len_ff[cpu_ff]};
                  end
               end
            end
            rsp_valid_in = 1'b1;
            rsp_idx_in   = 3'(cpu_ff);
            rsp_rv_in    = busy_in[cpu_ff];
            rsp_task_in  = busy_in[cpu_ff] ? id_in[cpu_ff] : 8'd0;
            rsp_pw_in    = on_in[cpu_ff];
            rsp_qe_in    = qe_ff;
            rsp_sf_in    = 1'b0;
            rsp_last_in  = (cpu_ff == CW'(NUM_CPUS - 1));
            if (cpu_ff == CW'(NUM_CPUS - 1)) begin
               state_in = ST_IDLE;
            end else begin
               cpu_in   = cpu_ff + CW'(1);
               state_in = ST_CPU;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cpu_ff       <= '0;
         cnt_ff       <= '0;
         xv_ff        <= 1'b0;
         qe_ff        <= 1'b0;
         quantum_ff   <= psa_pkg::QUANTUM_RESET;
         step_ff      <= psa_pkg::AGING_RESET;
         on_ff        <= '1;
         busy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_CPUS; i++) begin
            rc_ff[i] <= 8'd0;
         end
      end else begin
         state_ff     <= state_in;
         cpu_ff       <= cpu_in;
         cnt_ff       <= cnt_in;
         xv_ff        <= xv_in;
         qe_ff        <= qe_in;
         quantum_ff   <= quantum_in;
         step_ff      <= step_in;
         on_ff        <= on_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         rc_ff        <= rc_in;
      end
      id_ff       <= id_in;
      pr_ff       <= pr_in;
      arr_ff      <= arr_in;
      len_ff      <= len_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_rv_ff   <= rsp_rv_in;
      rsp_task_ff <= rsp_task_in;
      rsp_pw_ff   <= rsp_pw_in;
      rsp_qe_ff   <= rsp_qe_in;
      rsp_ap_ff   <= rsp_ap_in;
      rsp_na_ff   <= rsp_na_in;
      rsp_sf_ff   <= rsp_sf_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cpu_index       = rsp_idx_ff;
   assign rsp_running_valid   = rsp_rv_ff;
   assign rsp_running_task    = rsp_task_ff;
   assign rsp_cpu_powered     = rsp_pw_ff;
   assign rsp_quantum_expired = rsp_qe_ff;
   assign rsp_aging_preempted = rsp_ap_ff;
   assign rsp_newly_assigned  = rsp_na_ff;
   assign rsp_store_full      = rsp_sf_ff;
   assign rsp_last            = rsp_last_ff;

   // A response beat follows either an accepted item or sequencer work.
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($past(accept) || ($past(state_ff) == ST_DECIDE)))
      else $error("response beat without a cause");

   // The spare slot never outlives the processor visit that filled it.
   a_spare_clear: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !xv_ff)
      else $error("spare slot still occupied while idle");

   // A processor only runs a task while powered.
   a_busy_on: assert property (@(posedge clock) disable iff (reset)
      (busy_ff & ~on_ff) == '0)
      else $error("busy processor is powered off");

   // A tick ends with the last processor's beat and returns to idle.
   a_tick_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> (state_ff == ST_IDLE))
      else $error("last beat while sequencer still running");

endmodule
